/* rtl/mcp_pkg.sv */
// Shared types and constants for the message coalescing packetizer.
`default_nettype none
package mcp_pkg;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] msg_len;
  } in_t;

  typedef struct packed {
    logic        event_kind;
    logic [13:0] packet_bytes;
    logic [12:0] message_count;
    logic        oversize;
    logic        last_result;
  } out_t;

  localparam logic [1:0] CMD_ENQ   = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_FORCE = 2'd2;

  localparam logic [2:0] REG_COALESCE = 3'd0;
  localparam logic [2:0] REG_FRAMING  = 3'd1;
  localparam logic [2:0] REG_CAP      = 3'd2;
  localparam logic [2:0] REG_INTERVAL = 3'd3;
  localparam logic [2:0] REG_DRIFT    = 3'd4;

  localparam logic EV_SENT    = 1'b0;
  localparam logic EV_DISCARD = 1'b1;

  localparam logic [13:0] CAP_MIN    = 14'd512;
  localparam logic [13:0] CAP_MAX    = 14'd8192;
  localparam logic [17:0] HDR_BYTES  = 18'd2;
  localparam int          RESULT_MAX = 64;

  typedef enum logic [3:0] {
    OP_NONE, OP_ACCEPT, OP_CHK_LOAD, OP_SAVE_FILL, OP_FL_LEG, OP_FL_INIT,
    OP_PKT_INIT, OP_PKT_STEP, OP_PKT_EMIT, OP_ENQ_DISC, OP_ENQ_WRITE,
    OP_LEG_ENQ, OP_CHK_SCHED, OP_CHK_CLAMP, OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       enable;
    logic       framing;
    logic       len_zero;
    logic       len_big;
    logic       count_zero;
    logic       no_room;
    logic       n_tight;
    logic       n_full;
    logic       fill_not_less;
    logic       not_due;
    logic       budget_zero;
    logic       walk_stop;
    logic       interval_zero;
    logic       hold_valid;
    logic       can_emit;
    logic       out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

/* rtl/mcp_ctrl.sv */
// Controller state machine that sequences enqueue, flush and pacing steps.
`default_nettype none
module mcp_ctrl import mcp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      ctl
);

  typedef enum logic [15:0] {
    S_IDLE      = 16'h0001,
    S_DISPATCH  = 16'h0002,
    S_ENQ_TEST  = 16'h0004,
    S_ENQ_AFTER = 16'h0008,
    S_ENQ_FINAL = 16'h0010,
    S_ENQ_WRITE = 16'h0020,
    S_LEG_ENQ   = 16'h0040,
    S_CHK_A     = 16'h0080,
    S_CHK_B     = 16'h0100,
    S_CHK_C     = 16'h0200,
    S_FL_START  = 16'h0400,
    S_PKT_START = 16'h0800,
    S_PKT_FETCH = 16'h1000,
    S_PKT_EXAM  = 16'h2000,
    S_PKT_EMIT  = 16'h4000,
    S_FINISH    = 16'h8000
  } state_t;

  state_t state_r, state_nxt;
  logic   ret_enq_r, ret_enq_nxt;
  logic   force_chk;
  state_t ret_state;

  assign force_chk = (stat.cmd == CMD_FORCE);
  assign ret_state = ret_enq_r ? S_ENQ_AFTER : S_CHK_B;
  assign in_stall  = (state_r != S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    ret_enq_nxt = ret_enq_r;
    ctl.op      = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.op    = OP_ACCEPT;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!stat.enable) begin
          state_nxt = S_FINISH;
        end else begin
          case (stat.cmd)
            CMD_ENQ: begin
              if (stat.len_zero || stat.len_big) state_nxt = S_FINISH;
              else if (!stat.framing)            state_nxt = S_LEG_ENQ;
              else                               state_nxt = S_ENQ_TEST;
            end
            CMD_TICK, CMD_FORCE: state_nxt = S_CHK_A;
            default: state_nxt = S_FINISH;
          endcase
        end
      end
      S_ENQ_TEST: begin
        if (!stat.count_zero && stat.no_room && !stat.n_tight) begin
          ctl.op      = OP_SAVE_FILL;
          ret_enq_nxt = 1'b1;
          state_nxt   = S_FL_START;
        end else begin
          state_nxt = S_ENQ_FINAL;
        end
      end
      S_ENQ_AFTER: state_nxt = stat.fill_not_less ? S_ENQ_FINAL : S_ENQ_TEST;
      S_ENQ_FINAL: begin
        if (!stat.no_room) begin
          state_nxt = S_ENQ_WRITE;
        end else if (stat.count_zero || stat.can_emit) begin
          ctl.op    = OP_ENQ_DISC;
          state_nxt = S_ENQ_WRITE;
        end
      end
      S_ENQ_WRITE: begin
        ctl.op    = OP_ENQ_WRITE;
        state_nxt = S_FINISH;
      end
      S_LEG_ENQ: begin
        if (stat.count_zero || stat.can_emit) begin
          ctl.op    = OP_LEG_ENQ;
          state_nxt = S_FINISH;
        end
      end
      S_CHK_A: begin
        ctl.op = OP_CHK_LOAD;
        if (!force_chk && stat.not_due) begin
          state_nxt = S_FINISH;
        end else if (!stat.count_zero) begin
          ret_enq_nxt = 1'b0;
          state_nxt   = S_FL_START;
        end else if (!force_chk) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_CHK_B;
        end
      end
      S_CHK_B: begin
        ctl.op    = OP_CHK_SCHED;
        state_nxt = stat.interval_zero ? S_FINISH : S_CHK_C;
      end
      S_CHK_C: begin
        ctl.op    = OP_CHK_CLAMP;
        state_nxt = S_FINISH;
      end
      S_FL_START: begin
        if (stat.count_zero) begin
          state_nxt = ret_state;
        end else if (!stat.framing) begin
          if (stat.can_emit) begin
            ctl.op    = OP_FL_LEG;
            state_nxt = ret_state;
          end
        end else begin
          ctl.op    = OP_FL_INIT;
          state_nxt = S_PKT_START;
        end
      end
      S_PKT_START: begin
        if (stat.budget_zero || stat.count_zero || stat.n_full) begin
          state_nxt = ret_state;
        end else begin
          ctl.op    = OP_PKT_INIT;
          state_nxt = S_PKT_FETCH;
        end
      end
      S_PKT_FETCH: state_nxt = S_PKT_EXAM;
      S_PKT_EXAM: begin
        ctl.op    = OP_PKT_STEP;
        state_nxt = stat.walk_stop ? S_PKT_EMIT : S_PKT_FETCH;
      end
      S_PKT_EMIT: begin
        if (stat.can_emit) begin
          ctl.op    = OP_PKT_EMIT;
          state_nxt = S_PKT_START;
        end
      end
      S_FINISH: begin
        if (!stat.hold_valid || stat.out_free) begin
          ctl.op    = OP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ret_enq_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ret_enq_r <= ret_enq_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/mcp_dp.sv */
// Datapath: configuration, length queue memory, packet walk, pacing and result staging.
`default_nettype none
module mcp_dp import mcp_pkg::*; #(
  parameter int BUF_BYTES    = 8192,
  parameter int QUEUE_DEPTH  = 4096,
  parameter int FLUSH_BUDGET = 2
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_t      in_data,
  input  wire logic     cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [15:0] cfg_wdata,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_t          out_data,
  input  wire ctl_cmd_t ctl,
  output dp_stat_t      stat
);

  localparam int QA = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int FW = $clog2(BUF_BYTES + 1);
  localparam int BW = $clog2(FLUSH_BUDGET + 1);
  localparam int NW = $clog2(RESULT_MAX + 1);

  function automatic logic [QA-1:0] qnext(input logic [QA-1:0] i);
    logic [QA:0] s;
    s = {1'b0, i} + 1'b1;
    return (s >= (QA+1)'(QUEUE_DEPTH)) ? '0 : s[QA-1:0];
  endfunction

  logic        en_r, en_nxt, frm_r, frm_nxt;
  logic [13:0] cap_r, cap_nxt;
  logic [15:0] ivl_r, ivl_nxt, drift_r, drift_nxt;
  logic [1:0]  cmd_r, cmd_nxt;
  logic [15:0] len_r, len_nxt;
  logic [QA-1:0] head_r, head_nxt, tail_r, tail_nxt, idx_r, idx_nxt;
  logic [CW-1:0] count_r, count_nxt, cnt_r, cnt_nxt;
  logic [FW-1:0] fill_r, fill_nxt, before_r, before_nxt;
  logic [31:0] now_r, now_nxt, next_r, next_nxt;
  logic [BW-1:0] budget_r, budget_nxt;
  logic [16:0] total_r, total_nxt;
  logic        over_r, over_nxt;
  logic [NW-1:0] n_r, n_nxt;
  out_t        hold_r, hold_nxt, out_r, out_nxt;
  logic        hold_valid_r, hold_valid_nxt, out_valid_r, out_valid_nxt;

  logic [15:0]   mem [QUEUE_DEPTH];
  logic [15:0]   rdata_r;
  logic          mem_we;
  logic [QA-1:0] mem_wa;

  logic [13:0] cap;
  logic [17:0] cap18, len_frame, fr, tot18, fill18;
  logic        ovs_case, ovf_case, out_free;
  logic [31:0] eff_next, lag, due_diff;
  logic        now_before;
  logic        e_valid;
  out_t        e_data;

  assign cap   = (cap_r < CAP_MIN) ? CAP_MIN : ((cap_r > CAP_MAX) ? CAP_MAX : cap_r);
  assign cap18 = 18'(cap);
  assign len_frame = 18'(len_r) + HDR_BYTES;
  assign fill18    = 18'(fill_r);
  assign fr        = 18'(rdata_r) + HDR_BYTES;
  assign tot18     = 18'(total_r) + fr;
  assign ovs_case  = (total_r == '0) && (fr > cap18);
  assign ovf_case  = !ovs_case && (tot18 > cap18);
  assign eff_next  = (next_r == '0) ? now_r : next_r;
  assign due_diff  = now_r - eff_next;
  assign now_before = due_diff[31];
  assign lag       = now_r - next_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    stat.cmd        = cmd_r;
    stat.enable     = en_r;
    stat.framing    = frm_r;
    stat.len_zero   = (len_r == '0);
    stat.len_big    = frm_r ? (len_frame > 18'(BUF_BYTES)) : (18'(len_r) > 18'(BUF_BYTES));
    stat.count_zero = (count_r == '0);
    stat.no_room    = (fill18 + len_frame > 18'(BUF_BYTES)) ||
                      (count_r >= CW'(QUEUE_DEPTH));
    stat.n_tight    = ((NW+1)'(n_r) + (NW+1)'(FLUSH_BUDGET + 1)) > (NW+1)'(RESULT_MAX);
    stat.n_full     = (n_r >= NW'(RESULT_MAX));
    stat.fill_not_less = (fill_r >= before_r);
    stat.not_due    = now_before;
    stat.budget_zero = (budget_r == '0);
    stat.walk_stop  = ovs_case || ovf_case || ((cnt_r + 1'b1) == count_r);
    stat.interval_zero = (ivl_r == '0);
    stat.hold_valid = hold_valid_r;
    stat.can_emit   = !hold_valid_r || out_free;
    stat.out_free   = out_free;
  end

  always_comb begin
    en_nxt = en_r; frm_nxt = frm_r; cap_nxt = cap_r; ivl_nxt = ivl_r; drift_nxt = drift_r;
    cmd_nxt = cmd_r; len_nxt = len_r;
    head_nxt = head_r; tail_nxt = tail_r; count_nxt = count_r; fill_nxt = fill_r;
    idx_nxt = idx_r; cnt_nxt = cnt_r; total_nxt = total_r; over_nxt = over_r;
    before_nxt = before_r; budget_nxt = budget_r;
    now_nxt = now_r; next_nxt = next_r; n_nxt = n_r;
    hold_nxt = hold_r; hold_valid_nxt = hold_valid_r;
    out_nxt = out_r; out_valid_nxt = out_valid_r && out_stall;
    mem_we = 1'b0; mem_wa = tail_r;
    e_valid = 1'b0;
    e_data  = '{event_kind: EV_SENT, packet_bytes: 14'(total_r),
                message_count: 13'(cnt_r), oversize: over_r, last_result: 1'b0};

    case (ctl.op)
      OP_ACCEPT: begin
        cmd_nxt = in_data.cmd;
        len_nxt = in_data.msg_len;
        n_nxt   = '0;
        if (in_data.cmd == CMD_TICK) now_nxt = now_r + 1'b1;
      end
      OP_CHK_LOAD:  next_nxt = eff_next;
      OP_SAVE_FILL: before_nxt = fill_r;
      OP_FL_LEG: begin
        e_valid = 1'b1;
        e_data  = '{event_kind: EV_SENT, packet_bytes: 14'(fill_r), message_count: 13'd1,
                    oversize: (fill18 > cap18), last_result: 1'b0};
        head_nxt = '0; tail_nxt = '0; count_nxt = '0; fill_nxt = '0;
      end
      OP_FL_INIT: budget_nxt = BW'(FLUSH_BUDGET);
      OP_PKT_INIT: begin
        budget_nxt = budget_r - 1'b1;
        total_nxt  = '0;
        cnt_nxt    = '0;
        over_nxt   = 1'b0;
        idx_nxt    = head_r;
      end
      OP_PKT_STEP: begin
        if (ovs_case) begin
          total_nxt = fr[16:0];
          cnt_nxt   = CW'(1);
          over_nxt  = 1'b1;
          idx_nxt   = qnext(idx_r);
        end else if (!ovf_case) begin
          total_nxt = tot18[16:0];
          cnt_nxt   = cnt_r + 1'b1;
          idx_nxt   = qnext(idx_r);
        end
      end
      OP_PKT_EMIT: begin
        e_valid   = 1'b1;
        head_nxt  = idx_r;
        count_nxt = count_r - cnt_r;
        fill_nxt  = (18'(total_r) > fill18) ? '0 : FW'(fill18 - 18'(total_r));
      end
      OP_ENQ_DISC: begin
        e_valid = (count_r != '0);
        e_data  = '{event_kind: EV_DISCARD, packet_bytes: 14'(fill_r),
                    message_count: 13'(count_r), oversize: 1'b0, last_result: 1'b0};
        head_nxt = '0; tail_nxt = '0; count_nxt = '0; fill_nxt = '0;
      end
      OP_ENQ_WRITE: begin
        mem_we    = 1'b1;
        mem_wa    = tail_r;
        tail_nxt  = qnext(tail_r);
        count_nxt = count_r + 1'b1;
        fill_nxt  = FW'(fill18 + len_frame);
      end
      OP_LEG_ENQ: begin
        e_valid = (count_r != '0);
        e_data  = '{event_kind: EV_DISCARD, packet_bytes: 14'(fill_r),
                    message_count: 13'(count_r), oversize: 1'b0, last_result: 1'b0};
        mem_we    = 1'b1;
        mem_wa    = '0;
        head_nxt  = '0;
        tail_nxt  = qnext('0);
        count_nxt = CW'(1);
        fill_nxt  = FW'(len_r);
      end
      OP_CHK_SCHED: begin
        if (ivl_r == '0) next_nxt = now_r;
        else if ((cmd_r == CMD_FORCE) && now_before) next_nxt = now_r + 32'(ivl_r);
        else next_nxt = next_r + 32'(ivl_r);
      end
      OP_CHK_CLAMP: begin
        // A schedule that has fallen too far behind restarts from the current tick.
        if (!lag[31] && (lag > 32'(drift_r))) next_nxt = now_r + 32'(ivl_r);
      end
      OP_FINISH: begin
        if (hold_valid_r) begin
          out_nxt             = hold_r;
          out_nxt.last_result = 1'b1;
          out_valid_nxt       = 1'b1;
          hold_valid_nxt      = 1'b0;
        end
      end
      default: ;
    endcase

    // Each new word pushes the held one out, so the final word can carry the last flag.
    if (e_valid && !n_r[NW-1]) begin
      n_nxt = n_r + 1'b1;
      if (hold_valid_r) begin
        out_nxt       = hold_r;
        out_valid_nxt = 1'b1;
      end
      hold_nxt       = e_data;
      hold_valid_nxt = 1'b1;
    end

    if (cfg_we) begin
      case (cfg_idx)
        REG_COALESCE: en_nxt = cfg_wdata[0];
        REG_FRAMING: begin
          frm_nxt = cfg_wdata[0];
          if (cfg_wdata[0] != frm_r) begin
            head_nxt = '0; tail_nxt = '0; count_nxt = '0; fill_nxt = '0;
          end
        end
        REG_CAP:      cap_nxt   = cfg_wdata[13:0];
        REG_INTERVAL: ivl_nxt   = cfg_wdata;
        REG_DRIFT:    drift_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= len_r;
    rdata_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b1; frm_r <= 1'b1; cap_r <= 14'd1200; ivl_r <= 16'd2; drift_r <= 16'd15;
      head_r <= '0; tail_r <= '0; count_r <= '0; fill_r <= '0;
      now_r <= '0; next_r <= '0; n_r <= '0; budget_r <= '0;
      hold_valid_r <= 1'b0; out_valid_r <= 1'b0;
    end else begin
      en_r <= en_nxt; frm_r <= frm_nxt; cap_r <= cap_nxt; ivl_r <= ivl_nxt;
      drift_r <= drift_nxt;
      head_r <= head_nxt; tail_r <= tail_nxt; count_r <= count_nxt; fill_r <= fill_nxt;
      now_r <= now_nxt; next_r <= next_nxt; n_r <= n_nxt; budget_r <= budget_nxt;
      hold_valid_r <= hold_valid_nxt; out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; len_r <= len_nxt; idx_r <= idx_nxt; cnt_r <= cnt_nxt;
    total_r <= total_nxt; over_r <= over_nxt; before_r <= before_nxt;
    hold_r <= hold_nxt; out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

/* rtl/message_coalescing_packetizer.sv */
// Top level of the message coalescing packetizer: controller plus datapath.
// An item is taken while the controller is idle; in_stall stays high until its last step is done.
// Each length read passes through a fetch state and an examine state, and each packet through
// a start state and an emit state; an enqueue may run flush rounds before its write.
// A stalled output word holds the emit step and the last step.
// Reset is synchronous and active low; no clearing pass is needed after it.
`default_nettype none
module message_coalescing_packetizer import mcp_pkg::*; #(
  parameter int BUF_BYTES    = 8192,
  parameter int QUEUE_DEPTH  = 4096,
  parameter int FLUSH_BUDGET = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [15:0] cfg_wdata
);

  ctl_cmd_t ctl;
  dp_stat_t stat;

  mcp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  mcp_dp #(
    .BUF_BYTES    (BUF_BYTES),
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .FLUSH_BUDGET (FLUSH_BUDGET)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .ctl       (ctl),
    .stat      (stat)
  );

endmodule
`default_nettype wire

/* rtl/mcp_checker.sv */
// Port-level checker for the packetizer and its bind.
`default_nettype none
module mcp_checker import mcp_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

  a_discard_not_oversize: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_kind == EV_DISCARD) |-> !out_data.oversize)
    else $error("discard word flagged oversize");

  a_oversize_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.oversize |-> out_data.message_count == 13'd1)
    else $error("oversize packet holds more than one message");

  a_sent_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_kind == EV_SENT) |-> out_data.message_count != 13'd0)
    else $error("sent packet holds no message");

endmodule

bind message_coalescing_packetizer mcp_checker u_mcp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the message coalescing packetizer.
module tb_top;
  import mcp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUF_SIZE = 8192;
  localparam int QDEPTH = 4096;
  localparam int BUDGET = 2;
  localparam int WDOG_LIMIT = 20000;
  localparam logic [1:0] CMD_RSVD = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = REG_COALESCE;
  logic [15:0] cfg_wdata = '0;

  message_coalescing_packetizer i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Predictor state.
  bit m_enable, m_framing;
  bit [13:0] m_cap;
  bit [15:0] m_interval, m_drift;
  bit [15:0] m_lens [QDEPTH];
  int unsigned m_head, m_tail, m_count, m_fill;
  bit [31:0] m_now, m_next;
  out_t step_words [$];
  out_t expected_words [$];

  int errors = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;

  function automatic bit tick_lt(bit [31:0] a, bit [31:0] b);
    bit [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic int unsigned next_idx(int unsigned i);
    return (i + 1 >= QDEPTH) ? 0 : i + 1;
  endfunction

  function automatic void drop_pending();
    m_head = 0;
    m_tail = 0;
    m_count = 0;
    m_fill = 0;
  endfunction

  function automatic void push_word(bit kind, int unsigned bytes, int unsigned cnt, bit over);
    out_t w;
    if (step_words.size() >= RESULT_MAX) return;
    w.event_kind = kind;
    w.packet_bytes = bytes[13:0];
    w.message_count = cnt[12:0];
    w.oversize = over;
    w.last_result = 1'b0;
    step_words.push_back(w);
  endfunction

  function automatic int unsigned sat_cap();
    if (m_cap < CAP_MIN) return CAP_MIN;
    if (m_cap > CAP_MAX) return CAP_MAX;
    return m_cap;
  endfunction

  function automatic void flush_packets();
    int unsigned cap, total, cnt, idx, fr;
    bit over;
    int budget;
    cap = sat_cap();
    budget = BUDGET;
    if (m_count == 0) return;
    if (!m_framing) begin
      push_word(EV_SENT, m_fill, 1, m_fill > cap);
      drop_pending();
      return;
    end
    while (budget > 0 && m_count > 0 && step_words.size() < RESULT_MAX) begin
      total = 0; cnt = 0; over = 0; idx = m_head;
      budget--;
      for (int unsigned i = 0; i < m_count; i++) begin
        fr = m_lens[idx] + 2;
        if (total == 0 && fr > cap) begin
          total = fr; cnt = 1; over = 1;
          break;
        end
        if (total + fr > cap) break;
        total += fr;
        cnt++;
        idx = next_idx(idx);
      end
      push_word(EV_SENT, total, cnt, over);
      for (int unsigned i = 0; i < cnt; i++) m_head = next_idx(m_head);
      m_count -= cnt;
      m_fill = (total > m_fill) ? 0 : m_fill - total;
    end
  endfunction

  function automatic bit lacks_room(int unsigned len);
    return (m_fill + len + 2 > BUF_SIZE) || (m_count >= QDEPTH);
  endfunction

  function automatic void enqueue_msg(int unsigned len);
    int unsigned prev;
    if (len == 0) return;
    if (!m_framing) begin
      if (len > BUF_SIZE) return;
      if (m_count > 0) push_word(EV_DISCARD, m_fill, m_count, 0);
      drop_pending();
      m_lens[0] = 16'(len);
      m_tail = next_idx(0);
      m_count = 1;
      m_fill = len;
      return;
    end
    if (len + 2 > BUF_SIZE) return;
    while (m_count > 0 && lacks_room(len)) begin
      prev = m_fill;
      if (step_words.size() + BUDGET + 1 > RESULT_MAX) break;
      flush_packets();
      if (m_fill >= prev) break;
    end
    if (lacks_room(len)) begin
      if (m_count > 0) push_word(EV_DISCARD, m_fill, m_count, 0);
      drop_pending();
    end
    m_lens[m_tail] = 16'(len);
    m_tail = next_idx(m_tail);
    m_count++;
    m_fill += len + 2;
  endfunction

  function automatic void pacing_check(bit forced);
    bit [31:0] lag;
    if (m_next == 0) m_next = m_now;
    if (!forced && tick_lt(m_now, m_next)) return;
    if (m_count > 0) flush_packets();
    else if (!forced) return;
    if (m_interval == 0) begin
      m_next = m_now;
      return;
    end
    if (forced && tick_lt(m_now, m_next)) m_next = m_now + m_interval;
    else m_next += m_interval;
    lag = m_now - m_next;
    if (!lag[31] && lag > m_drift) m_next = m_now + m_interval;
  endfunction

  function automatic void predict_item(in_t it);
    step_words.delete();
    if (it.cmd == CMD_TICK) m_now++;
    if (m_enable) begin
      case (it.cmd)
        CMD_ENQ: enqueue_msg(it.msg_len);
        CMD_TICK: pacing_check(1'b0);
        CMD_FORCE: pacing_check(1'b1);
        default: ;
      endcase
    end
    if (step_words.size() > 0) step_words[step_words.size() - 1].last_result = 1'b1;
    foreach (step_words[i]) expected_words.push_back(step_words[i]);
  endfunction

  function automatic void model_reset();
    m_enable = 1; m_framing = 1; m_cap = 1200; m_interval = 2; m_drift = 15;
    drop_pending();
    m_now = 0; m_next = 0;
  endfunction

  // Result checker.
  always @(posedge clk) begin
    out_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", out_data);
      end else begin
        exp_w = expected_words.pop_front();
        if (out_data !== exp_w) begin
          errors++;
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_w, out_data);
        end
      end
    end
  end

  // Receiver stall pattern, with a long hold-off on request.
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 15);
    if (hold_off) out_stall <= 1'b1;
    else if (r < 3) out_stall <= 1'b1;
    else if (r < 5) out_stall <= ($urandom_range(0, 1) == 1);
    else out_stall <= 1'b0;
  end

  // Watchdog on cycles with no accepted word.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  int burst_left = 0;

  task automatic send_item(logic [1:0] cmd, logic [15:0] len);
    in_t it;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      repeat ($urandom_range(0, 4)) @(posedge clk);
    end
    burst_left--;
    it.cmd = cmd;
    it.msg_len = len;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(it);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (expected_words.size() > 0) @(posedge clk);
    // Items that give no word may still be in flight.
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_COALESCE: m_enable = val[0];
      REG_FRAMING: begin
        if (val[0] != m_framing) drop_pending();
        m_framing = val[0];
      end
      REG_CAP: m_cap = val[13:0];
      REG_INTERVAL: m_interval = val;
      REG_DRIFT: m_drift = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 16'($urandom_range(1, 600));
    if (r < 8) return 16'($urandom_range(600, 8190));
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic test_directed();
    send_item(CMD_ENQ, 16'd0);
    send_item(CMD_ENQ, 16'hFFFF);
    send_item(CMD_ENQ, 16'd8190);
    send_item(CMD_ENQ, 16'd8191);
    send_item(CMD_ENQ, 16'd1);
    send_item(CMD_FORCE, 16'd0);
    send_item(CMD_FORCE, 16'd0);
    send_item(CMD_RSVD, 16'hAAAA);
    send_item(CMD_ENQ, 16'd3000);
    send_item(CMD_ENQ, 16'd100);
    send_item(CMD_ENQ, 16'd200);
    send_item(CMD_TICK, 16'h5555);
    send_item(CMD_TICK, 16'd0);
    send_item(CMD_TICK, 16'd0);
    for (int i = 0; i < 6; i++) send_item(CMD_ENQ, 16'd1500);
    send_item(CMD_FORCE, 16'd0);
    send_item(CMD_FORCE, 16'd0);
    drain();
  endtask

  task automatic test_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r < 6) send_item(CMD_ENQ, rand_len());
      else if (r < 8) send_item(CMD_TICK, 16'($urandom));
      else if (r < 9) send_item(CMD_FORCE, 16'($urandom));
      else send_item(CMD_RSVD, 16'($urandom));
    end
    drain();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++) begin
        send_item(CMD_ENQ, 16'd700);
        send_item(CMD_FORCE, 16'd0);
      end
    join
    drain();
  endtask

  task automatic test_config_sweep();
    write_reg(REG_CAP, 16'd512);
    write_reg(REG_INTERVAL, 16'd0);
    write_reg(REG_DRIFT, 16'd0);
    test_random(15);
    write_reg(REG_CAP, 16'h3FFF);
    write_reg(REG_INTERVAL, 16'hFFFF);
    write_reg(REG_DRIFT, 16'hFFFF);
    test_random(10);
    write_reg(REG_CAP, 16'd100);
    write_reg(REG_INTERVAL, 16'd3);
    write_reg(REG_DRIFT, 16'd1);
    send_item(CMD_ENQ, 16'd50);
    drain();
    write_reg(REG_FRAMING, 16'h0000);
    test_random(15);
    send_item(CMD_ENQ, 16'd8192);
    send_item(CMD_ENQ, 16'd8193);
    send_item(CMD_ENQ, 16'd400);
    send_item(CMD_FORCE, 16'd0);
    drain();
    write_reg(REG_FRAMING, 16'hFFFF);
    write_reg(REG_COALESCE, 16'h0000);
    test_random(5);
    write_reg(REG_COALESCE, 16'h0001);
    write_reg(REG_CAP, 16'd8192);
    write_reg(REG_INTERVAL, 16'd2);
    write_reg(REG_DRIFT, 16'd15);
    test_random(15);
  endtask

  initial begin
    model_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(20);
    test_config_sweep();
    if (errors == 0 && expected_words.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/mcp_pkg.sv
rtl/mcp_ctrl.sv
rtl/mcp_dp.sv
rtl/message_coalescing_packetizer.sv
rtl/mcp_checker.sv
verif/tb_top.sv
